FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("assert");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("assert");
`else
`define ASSERT_IMPLY(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

FILE: rtl/core/trc_pkg.sv
// ----------------------------------------------------------------------------
// trc_pkg
// Types and constants for the touch report calibrator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package trc_pkg;
  typedef enum logic [1:0] {
    OP_POLL  = 2'd0,
    OP_START = 2'd1,
    OP_ADD   = 2'd2,
    OP_END   = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FEW      = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch request, do its register updates
    logic map_start; // start both axis mappings
    logic fit_clr;   // reset extreme search
    logic fit_step;  // examine point at scan index
    logic fit_done;  // commit the fit
    logic out_load;  // capture result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic     is_map;   // request needs mapping
    logic     is_fit;   // request needs fit scan
    logic     map_done;
    logic     scan_last;
  } dp_sts_t;
endpackage

FILE: rtl/core/trc_ram.sv
// ----------------------------------------------------------------------------
// trc_ram
// Generic single-port-write, one-read RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module trc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/trc_div.sv
// ----------------------------------------------------------------------------
// trc_div
// Axis map: (v-off)*num/den+base, restoring division, truncating, saturating.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module trc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [14:0]        v,
  input  logic [14:0]        off,
  input  logic signed [12:0] num,
  input  logic [14:0]        den,
  input  logic [11:0]        base,
  output logic               busy,
  output logic signed [16:0] result
);
  // |product| < 2^28
  logic [5:0]         cnt_r, cnt_nxt;
  logic               neg_r;
  logic [27:0]        quo_r;
  logic [14:0]        rem_r;
  logic [14:0]        den_r;
  logic [11:0]        base_r;
  logic signed [16:0] diff;
  logic signed [29:0] prod;
  logic [15:0]        trial;
  logic signed [29:0] q_s;
  logic signed [30:0] sum;

  assign diff = $signed({2'b00, v}) - $signed({2'b00, off});
  assign prod = diff * num;
  assign trial = {rem_r, quo_r[27]};
  assign q_s = neg_r ? -$signed({2'b00, quo_r}) : $signed({2'b00, quo_r});
  assign sum = 31'(q_s) + $signed({19'd0, base_r});
  assign busy = (cnt_r != 6'd0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (start) begin
      cnt_nxt = 6'd29;
    end else if (cnt_r != 6'd0) begin
      cnt_nxt = cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    if (start) begin
      neg_r  <= prod[29];
      quo_r  <= 28'(prod[29] ? -prod : prod);
      rem_r  <= '0;
      den_r  <= den;
      base_r <= base;
    end else if (cnt_r > 6'd1) begin
      if (trial >= {1'b0, den_r}) begin
        rem_r <= 15'(trial - {1'b0, den_r});
        quo_r <= {quo_r[26:0], 1'b1};
      end else begin
        rem_r <= trial[14:0];
        quo_r <= {quo_r[26:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (den_r == 15'd0) begin
      result = 17'($signed({5'd0, base_r}));
    end else if (sum > 31'sd65535) begin
      result = 17'sd65535;
    end else if (sum < -31'sd65536) begin
      result = -17'sd65536;
    end else begin
      result = sum[16:0];
    end
  end
endmodule

FILE: rtl/core/trc_datapath.sv
// ----------------------------------------------------------------------------
// trc_datapath
// Request latch, point stores, fit scan, mapping units and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module trc_datapath
  import trc_pkg::*;
#(
  parameter int POINTS = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  dp_cmd_t      cmd,
  output dp_sts_t      sts,
  input  logic [1:0]   in_operation,
  input  logic         in_ready_line,
  input  logic [7:0]   in_status_byte,
  input  logic [7:0]   in_x_low_byte,
  input  logic [7:0]   in_x_high_byte,
  input  logic [7:0]   in_y_low_byte,
  input  logic [7:0]   in_y_high_byte,
  input  logic [14:0]  in_taken_x,
  input  logic [14:0]  in_taken_y,
  input  logic [11:0]  in_expected_x,
  input  logic [11:0]  in_expected_y,
  output logic [1:0]   out_status_code,
  output logic         out_pen_down,
  output logic         out_coords_valid,
  output logic signed [16:0] out_x_out,
  output logic signed [16:0] out_y_out
);
  localparam int AW = $clog2(POINTS);
  localparam int CW = $clog2(POINTS + 1);

  logic        calib_r, valid_r, pen_r;
  logic [14:0] raw_x_r, raw_y_r;
  logic [CW-1:0] cnt_r;
  logic [14:0] off_x_r, off_y_r, den_x_r, den_y_r;
  logic [11:0] base_x_r, base_y_r;
  logic signed [12:0] num_x_r, num_y_r;

  // result staging
  logic [1:0]  st_r;
  logic        rp_r, rv_r, use_map_r;
  logic [14:0] rx_r, ry_r;
  logic [1:0]  op_r;

  // scan
  logic [AW-1:0] scan_r, rd_addr;
  logic          scan_v_r;
  logic [14:0]   mnx_r, mxx_r, mny_r, mxy_r;
  logic [11:0]   mnxo_r, mxxo_r, mnyo_r, mxyo_r;
  logic          first_r;
  logic [14:0]   tx_q, ty_q;
  logic [11:0]   ex_q, ey_q;

  logic          we;
  logic [14:0]   raw_x_in, raw_y_in;
  logic          mbx, mby;
  logic signed [16:0] mx, my;

  assign raw_x_in = 15'({in_x_high_byte, 7'd0} | {7'd0, in_x_low_byte});
  assign raw_y_in = 15'({in_y_high_byte, 7'd0} | {7'd0, in_y_low_byte});
  assign we = cmd.load && (op_t'(in_operation) == OP_ADD) && (cnt_r < CW'(POINTS));
  assign rd_addr = scan_r;

  trc_ram #(.WIDTH(15), .DEPTH(POINTS)) u_tx (.clk, .we, .waddr(cnt_r[AW-1:0]),
    .wdata(in_taken_x), .raddr(rd_addr), .rdata(tx_q));
  trc_ram #(.WIDTH(15), .DEPTH(POINTS)) u_ty (.clk, .we, .waddr(cnt_r[AW-1:0]),
    .wdata(in_taken_y), .raddr(rd_addr), .rdata(ty_q));
  trc_ram #(.WIDTH(12), .DEPTH(POINTS)) u_ex (.clk, .we, .waddr(cnt_r[AW-1:0]),
    .wdata(in_expected_x), .raddr(rd_addr), .rdata(ex_q));
  trc_ram #(.WIDTH(12), .DEPTH(POINTS)) u_ey (.clk, .we, .waddr(cnt_r[AW-1:0]),
    .wdata(in_expected_y), .raddr(rd_addr), .rdata(ey_q));

  trc_div u_mapx (.clk, .rst_n, .start(cmd.map_start), .v(rx_r), .off(off_x_r),
    .num(num_x_r), .den(den_x_r), .base(base_x_r), .busy(mbx), .result(mx));
  trc_div u_mapy (.clk, .rst_n, .start(cmd.map_start), .v(ry_r), .off(off_y_r),
    .num(num_y_r), .den(den_y_r), .base(base_y_r), .busy(mby), .result(my));

  assign sts.is_map    = use_map_r;
  assign sts.is_fit    = (op_t'(op_r) == OP_END) && (st_r == ST_OK);
  assign sts.map_done  = !mbx && !mby;
  // last entry's comparison step
  assign sts.scan_last = scan_v_r && (scan_r == AW'(POINTS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_r <= 1'b0; valid_r <= 1'b0; pen_r <= 1'b0;
      raw_x_r <= '0; raw_y_r <= '0; cnt_r <= '0;
      off_x_r <= '0; off_y_r <= '0; den_x_r <= '0; den_y_r <= '0;
      base_x_r <= '0; base_y_r <= '0; num_x_r <= '0; num_y_r <= '0;
      scan_r <= '0; scan_v_r <= 1'b0; first_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        op_r <= in_operation;
        st_r <= ST_OK; rp_r <= 1'b0; rv_r <= 1'b0; use_map_r <= 1'b0;
        rx_r <= '0; ry_r <= '0;
        unique case (op_t'(in_operation))
          OP_POLL: begin
            if (!in_ready_line) begin
              rp_r <= pen_r;
            end else begin
              rp_r <= in_status_byte[0];
              pen_r <= in_status_byte[0];
              rv_r <= 1'b1;
              use_map_r <= !calib_r && valid_r;
              if (in_status_byte[0]) begin
                raw_x_r <= raw_x_in; raw_y_r <= raw_y_in;
                rx_r <= raw_x_in; ry_r <= raw_y_in;
              end else begin
                rx_r <= raw_x_r; ry_r <= raw_y_r;
              end
            end
          end
          OP_START: begin
            calib_r <= 1'b1; cnt_r <= '0;
          end
          OP_ADD: begin
            if (cnt_r < CW'(POINTS)) begin
              cnt_r <= cnt_r + CW'(1);
              st_r <= (cnt_r + CW'(1) < CW'(POINTS)) ? ST_FEW : ST_OK;
            end else begin
              st_r <= ST_OVERFLOW;
            end
          end
          OP_END: begin
            calib_r <= 1'b0;
            if (cnt_r != CW'(POINTS)) st_r <= ST_FEW;
          end
          default: ;
        endcase
      end
      if (cmd.fit_clr) begin
        scan_r <= '0; scan_v_r <= 1'b0; first_r <= 1'b1;
      end
      if (cmd.fit_step) begin
        // scan_v_r marks read data of scan_r valid
        if (!scan_v_r) begin
          scan_v_r <= 1'b1;
        end else begin
          scan_v_r <= 1'b0;
          if (scan_r != AW'(POINTS - 1)) scan_r <= scan_r + AW'(1);
          first_r <= 1'b0;
          if (first_r || tx_q < mnx_r) begin mnx_r <= tx_q; mnxo_r <= ex_q; end
          if (first_r || ty_q < mny_r) begin mny_r <= ty_q; mnyo_r <= ey_q; end
          if (first_r) begin
            mxx_r <= tx_q; mxxo_r <= (tx_q != 0) ? ex_q : 12'd0;
            mxy_r <= ty_q; mxyo_r <= (ty_q != 0) ? ey_q : 12'd0;
          end else begin
            if (tx_q > mxx_r) begin mxx_r <= tx_q; mxxo_r <= ex_q; end
            if (ty_q > mxy_r) begin mxy_r <= ty_q; mxyo_r <= ey_q; end
          end
        end
      end
      if (cmd.fit_done) begin
        valid_r <= 1'b1;
        off_x_r <= mnx_r; base_x_r <= mnxo_r; den_x_r <= mxx_r - mnx_r;
        num_x_r <= 13'(mxxo_r - mnxo_r);
        off_y_r <= mny_r; base_y_r <= mnyo_r; den_y_r <= mxy_r - mny_r;
        num_y_r <= 13'(mxyo_r - mnyo_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_code  <= st_r;
      out_pen_down     <= rp_r;
      out_coords_valid <= rv_r;
      out_x_out <= use_map_r ? mx : $signed({2'b00, rx_r});
      out_y_out <= use_map_r ? my : $signed({2'b00, ry_r});
    end
  end
endmodule

FILE: rtl/core/trc_ctrl.sv
// ----------------------------------------------------------------------------
// trc_ctrl
// Sequencer: accepts a request, runs mapping or fit scan, hands off result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module trc_ctrl
  import trc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DISP = 5'b00010,
    S_MAP  = 5'b00100,
    S_SCAN = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;
  logic   fin;

  // free output register lets the next request start while one waits
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    fin = 1'b0;
    unique case (state_r)
      S_IDLE: if (in_valid && in_ready) begin
        cmd.load = 1'b1;
        state_nxt = S_DISP;
      end
      S_DISP: begin
        if (sts.is_map) begin
          cmd.map_start = 1'b1; state_nxt = S_MAP;
        end else if (sts.is_fit) begin
          cmd.fit_clr = 1'b1; state_nxt = S_SCAN;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_MAP: if (sts.map_done) state_nxt = S_FIN;
      S_SCAN: begin
        cmd.fit_step = 1'b1;
        if (sts.scan_last) state_nxt = S_FIN;
      end
      S_FIN: if (!ov_r || out_ready) begin
        fin = 1'b1;
        cmd.out_load = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // fit commits after final scan step's comparison; S_FIN follows that step
  always_comb begin
    ov_nxt = ov_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    if (fin) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
    end
  end

  `ASSERT_IMPLY(a_one_hot, clk, rst_n, 1'b1, $onehot(state_r))
  `ASSERT_IMPLY(a_no_accept_busy, clk, rst_n, state_r != S_IDLE, !in_ready)
  `ASSERT_NEXT(a_load_disp, clk, rst_n, cmd.load, state_r == S_DISP)
  `ASSERT_IMPLY(a_fin_outfree, clk, rst_n, fin, !ov_r || out_ready)
endmodule

FILE: rtl/core/touch_report_calibrator.sv
// ----------------------------------------------------------------------------
// touch_report_calibrator
// Touch report decoder with two-point linear calibration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
// One request at a time. Start, add, a raw or ready-low poll and an end
// without a fit give their result through S_DISP and S_FIN; a poll needing
// calibration runs two serial dividers in parallel; end of calibration
// scans the POINTS-entry point store, a read step and then a comparison step
// per entry. The next request is accepted as soon as the sequencer
// is idle, while the previous result may still sit in the output register;
// a held result only stalls the following one at its final load.
// No clearing pass after reset.
module touch_report_calibrator
  import trc_pkg::*;
#(
  parameter int POINTS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic        in_ready_line,
  input  logic [7:0]  in_status_byte,
  input  logic [7:0]  in_x_low_byte,
  input  logic [7:0]  in_x_high_byte,
  input  logic [7:0]  in_y_low_byte,
  input  logic [7:0]  in_y_high_byte,
  input  logic [14:0] in_taken_x,
  input  logic [14:0] in_taken_y,
  input  logic [11:0] in_expected_x,
  input  logic [11:0] in_expected_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status_code,
  output logic        out_pen_down,
  output logic        out_coords_valid,
  output logic signed [16:0] out_x_out,
  output logic signed [16:0] out_y_out
);
  dp_cmd_t cmd, cmd_c;
  dp_sts_t sts;
  logic    last_step_r;

  trc_ctrl u_ctrl (.clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .cmd(cmd_c), .sts);

  // the fit commits in the cycle after the final scan step, no later than output load
  always_ff @(posedge clk) begin
    if (!rst_n) last_step_r <= 1'b0;
    else        last_step_r <= cmd_c.fit_step && sts.scan_last;
  end
  always_comb begin
    cmd = cmd_c;
    cmd.fit_done = last_step_r;
  end

  trc_datapath #(.POINTS(POINTS)) u_dp (.clk, .rst_n, .cmd, .sts,
    .in_operation, .in_ready_line, .in_status_byte, .in_x_low_byte,
    .in_x_high_byte, .in_y_low_byte, .in_y_high_byte, .in_taken_x,
    .in_taken_y, .in_expected_x, .in_expected_y, .out_status_code,
    .out_pen_down, .out_coords_valid, .out_x_out, .out_y_out);
endmodule
